// ===== design/energy_pulse_accumulator_core_assert.svh =====
// Assertion macros for the energy pulse accumulator core.
// Uses the clock and reset signals of the including module's scope.
`ifndef ENERGY_PULSE_ACCUMULATOR_CORE_ASSERT_SVH
`define ENERGY_PULSE_ACCUMULATOR_CORE_ASSERT_SVH

// Check a consequence in the same cycle as its cause
`define EPA_CHK_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its cause
`define EPA_CHK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/epa_pkg.sv =====
// Shared types and constants for the energy pulse accumulator core.
// No dependencies; imported by energy_pulse_accumulator_core and its testbench.
package epa_pkg;

   localparam int PWR_W     = 32;
   localparam int PULSE_W   = 33;
   localparam int TOTAL_W   = 32;
   localparam int RES_W     = 33;
   localparam int THR_W     = 32;
   localparam int DIV_STEPS = 33;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);
   localparam logic [THR_W-1:0] EPP_RESET = THR_W'(1);

   typedef struct packed {
      logic [PWR_W-1:0] active_power;
      logic [PWR_W-1:0] apparent_power;
   } req_type;

   typedef struct packed {
      logic [PULSE_W-1:0] active_pulses_now;
      logic [PULSE_W-1:0] apparent_pulses_now;
      logic [TOTAL_W-1:0] active_pulse_total;
      logic [TOTAL_W-1:0] apparent_pulse_total;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIVIDE,
      S_WRITE
   } state_type;

endpackage

// ===== design/energy_pulse_accumulator_core.sv =====
// An accepted req beat runs the active channel divide, then the apparent channel divide, then the write state.
// A new req beat is taken only in the idle state, after the last tick is written; rsp_ready stalls hold the write.
// The work is done by one 33-step restoring divider shared by both channels in turn.
// Reset (synchronous, active high): residues and pulse totals clear, threshold returns to 1.
// Depends on epa_pkg and energy_pulse_accumulator_core_assert.svh.
`include "energy_pulse_accumulator_core_assert.svh"

module energy_pulse_accumulator_core
   import epa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [THR_W-1:0] csr_wr_data
);

   state_type          state_ff, state_in;
   logic               rsp_valid_ff;
   logic [THR_W-1:0]   epp_ff;
   logic [RES_W-1:0]   act_res_ff, app_res_ff;
   logic [TOTAL_W-1:0] act_cnt_ff, app_cnt_ff;

   logic [RES_W-1:0]   quo_ff;
   logic [THR_W-1:0]   rem_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               chan_ff;
   logic [PWR_W-1:0]   app_pwr_ff;
   logic [PULSE_W-1:0] act_now_ff, app_now_ff;
   rsp_type            rsp_data_ff;

   logic [THR_W-1:0]   thr;
   logic [RES_W-1:0]   trial, diff;
   logic               ge;
   logic [THR_W-1:0]   rem_step;
   logic [RES_W-1:0]   quo_step;
   logic               last;
   logic [RES_W-1:0]   act_sum, app_sum;

   logic load_act, step_en, finish_act, finish_app, rsp_load;

   // Zero threshold acts as one
   assign thr = (epp_ff == '0) ? THR_W'(1) : epp_ff;

   // One restoring divide step: shift in the next dividend bit, subtract if it fits
   assign trial    = {rem_ff, quo_ff[RES_W-1]};
   assign ge       = trial >= {1'b0, thr};
   assign diff     = trial - {1'b0, thr};
   assign rem_step = ge ? diff[THR_W-1:0] : trial[THR_W-1:0];
   assign quo_step = {quo_ff[RES_W-2:0], ge};
   assign last     = cnt_ff == LAST_STEP;

   // Residue plus this tick's power, modulo 2^33
   assign act_sum = act_res_ff + {1'b0, req_data.active_power};
   assign app_sum = app_res_ff + {1'b0, app_pwr_ff};

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DIVIDE;
         end
         S_DIVIDE: begin
            if (last && chan_ff) state_in = S_WRITE;
         end
         S_WRITE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready  = 1'b0;
      load_act   = 1'b0;
      step_en    = 1'b0;
      finish_act = 1'b0;
      finish_app = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            load_act  = req_valid;
         end
         S_DIVIDE: begin
            step_en    = 1'b1;
            finish_act = last && !chan_ff;
            finish_app = last && chan_ff;
         end
         S_WRITE: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: ;
      endcase
   end

   // Control, threshold, residues and totals
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         epp_ff       <= EPP_RESET;
         act_res_ff   <= '0;
         app_res_ff   <= '0;
         act_cnt_ff   <= '0;
         app_cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) epp_ff <= csr_wr_data;
         // Hold the result beat until taken
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (finish_act) begin
            act_res_ff <= {1'b0, rem_step};
            act_cnt_ff <= act_cnt_ff + quo_step[TOTAL_W-1:0];
         end
         if (finish_app) begin
            app_res_ff <= {1'b0, rem_step};
            app_cnt_ff <= app_cnt_ff + quo_step[TOTAL_W-1:0];
         end
      end
   end

   // Divider datapath: active channel first, then apparent
   always_ff @(posedge clock) begin
      if (load_act) begin
         quo_ff     <= act_sum;
         rem_ff     <= '0;
         cnt_ff     <= '0;
         chan_ff    <= 1'b0;
         app_pwr_ff <= req_data.apparent_power;
      end else if (step_en) begin
         if (finish_act) begin
            act_now_ff <= quo_step;
            quo_ff     <= app_sum;
            rem_ff     <= '0;
            cnt_ff     <= '0;
            chan_ff    <= 1'b1;
         end else if (finish_app) begin
            app_now_ff <= quo_step;
         end else begin
            quo_ff <= quo_step;
            rem_ff <= rem_step;
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.active_pulses_now    <= act_now_ff;
         rsp_data_ff.apparent_pulses_now  <= app_now_ff;
         rsp_data_ff.active_pulse_total   <= act_cnt_ff;
         rsp_data_ff.apparent_pulse_total <= app_cnt_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `EPA_CHK_NEXT(a_accept_starts_divide, req_valid && req_ready, state_ff == S_DIVIDE && cnt_ff == '0 && !chan_ff, "accepted beat did not start the active channel divide")
   `EPA_CHK_SAME(a_step_count_bound, state_ff == S_DIVIDE, cnt_ff <= LAST_STEP, "divide step counter ran past the last step")
   `EPA_CHK_NEXT(a_write_raises_valid, state_ff == S_WRITE && (!rsp_valid_ff || rsp_ready), rsp_valid_ff && state_ff == S_IDLE, "finished tick did not reach the output register")

endmodule

// ===== tb/tb_energy_pulse_accumulator_core.sv =====
`timescale 1ns / 100ps
// Testbench for energy_pulse_accumulator_core: drives power ticks, predicts pulse output.
// Depends on epa_pkg, the core RTL and the assertion header that the core includes.

module tb_energy_pulse_accumulator_core;
   import epa_pkg::*;

   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int DRAIN_CYCLES    = 100;
   localparam int PHASES          = 8;
   localparam int TICKS_PER_PHASE = 175;
   localparam int DRAIN_PCT       = 3;

   // Predicts pulse counts per tick and holds the results still owed by the core
   class pulse_scoreboard;
      logic [THR_W-1:0]   energy_step;
      logic [RES_W-1:0]   act_residue;
      logic [RES_W-1:0]   app_residue;
      logic [TOTAL_W-1:0] act_total;
      logic [TOTAL_W-1:0] app_total;
      rsp_type            owed_pulses[$];
      int                 errors;
      int                 ticks;
      int                 compared;

      function new();
         energy_step = EPP_RESET;
         act_residue = '0;
         app_residue = '0;
         act_total   = '0;
         app_total   = '0;
         errors      = 0;
         ticks       = 0;
         compared    = 0;
      endfunction

      // Add one tick of power to a channel; return the whole pulses made
      function logic [PULSE_W-1:0] integrate(inout logic [RES_W-1:0] residue,
                                             inout logic [TOTAL_W-1:0] total,
                                             input logic [PWR_W-1:0] power);
         logic [RES_W-1:0]   divisor;
         logic [RES_W-1:0]   acc;
         logic [PULSE_W-1:0] pulses;
         // a zero register acts as one unit per pulse
         divisor = (energy_step == '0) ? RES_W'(1) : RES_W'(energy_step);
         acc     = residue + RES_W'(power);
         pulses  = '0;
         if (acc >= divisor) begin
            pulses = acc / divisor;
            acc    = acc % divisor;
            total  = total + TOTAL_W'(pulses);
         end
         residue = acc;
         return pulses;
      endfunction

      function void note_tick(req_type beat);
         rsp_type want;
         want.active_pulses_now    = integrate(act_residue, act_total, beat.active_power);
         want.apparent_pulses_now  = integrate(app_residue, app_total, beat.apparent_power);
         want.active_pulse_total   = act_total;
         want.apparent_pulse_total = app_total;
         owed_pulses.push_back(want);
         ticks++;
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         errors++;
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (owed_pulses.size() == 0) begin
            report($sformatf("result beat with no tick pending: %h", got));
            return;
         end
         want = owed_pulses.pop_front();
         compared++;
         if (got.active_pulses_now !== want.active_pulses_now)
            report($sformatf("active_pulses_now got %h want %h",
                             got.active_pulses_now, want.active_pulses_now));
         if (got.apparent_pulses_now !== want.apparent_pulses_now)
            report($sformatf("apparent_pulses_now got %h want %h",
                             got.apparent_pulses_now, want.apparent_pulses_now));
         if (got.active_pulse_total !== want.active_pulse_total)
            report($sformatf("active_pulse_total got %h want %h",
                             got.active_pulse_total, want.active_pulse_total));
         if (got.apparent_pulse_total !== want.apparent_pulse_total)
            report($sformatf("apparent_pulse_total got %h want %h",
                             got.apparent_pulse_total, want.apparent_pulse_total));
      endtask
   endclass

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_ready;
   req_type          req_data    = '0;
   logic             rsp_valid;
   logic             rsp_ready   = 1'b0;
   rsp_type          rsp_data;
   logic             csr_wr_en   = 1'b0;
   logic [THR_W-1:0] csr_wr_data = '0;

   pulse_scoreboard  sb = new();
   int               gap_pct     = 0;
   int               stall_pct   = 0;
   int               drain_pct   = 0;
   int               settings    = 0;
   int               idle_cycles = 0;

   energy_pulse_accumulator_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Note accepted ticks, check accepted results, randomize the result stall
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         sb.note_tick(req_data);
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_data);
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // End the run when no beat moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Drop valid and hold until every owed result has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.owed_pulses.size() != 0);
   endtask

   // Present one tick and hold it until the core takes the beat
   task automatic send_tick(input logic [PWR_W-1:0] act, input logic [PWR_W-1:0] app);
      req_type beat;
      beat.active_power   = act;
      beat.apparent_power = app;
      if ($urandom_range(99) < drain_pct)
         wait_idle();
      if ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_threshold(input logic [THR_W-1:0] value);
      wait_idle();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.energy_step = value;
      settings++;
   endtask

   function automatic logic [THR_W-1:0] pick_threshold();
      case ($urandom_range(4))
         0:       return THR_W'(1);
         1:       return '0;
         2:       return '1;
         3:       return THR_W'($urandom_range(1, 1000));
         default: return THR_W'(1) << $urandom_range(THR_W - 1);
      endcase
   endfunction

   // Mix full-range power with edge values, small values and values up to the threshold
   function automatic logic [PWR_W-1:0] pick_power();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return PWR_W'($urandom_range(255));
         3:       return PWR_W'($urandom_range(sb.energy_step));
         default: return PWR_W'($urandom);
      endcase
   endfunction

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset threshold of one: every unit is a pulse, totals wrap quickly
      send_tick('0, '0);
      send_tick('1, '1);
      send_tick(32'd1, '0);
      send_tick(32'h8000_0000, 32'h7FFF_FFFF);

      // Largest threshold: stay below, then cross with a near-full residue
      write_threshold('1);
      send_tick(32'hFFFF_FFFE, 32'd1);
      send_tick('1, '1);
      send_tick(32'd1, 32'hFFFF_FFFE);
      send_tick('0, '0);

      write_threshold(32'd1000);
      send_tick(32'd999, 32'd500);
      send_tick(32'd1, 32'd1500);
      send_tick(32'd123456, 32'd7);

      // Zero threshold behaves as one
      write_threshold('0);
      send_tick(32'd5, '1);
      send_tick('0, 32'd1);
      send_tick('1, '0);

      // Lower the threshold under a large residue
      write_threshold(32'd1000);
      send_tick(32'd999, 32'd998);
      write_threshold(32'd3);
      send_tick('0, 32'd1);

      // Random phases, each with its own threshold and idling pattern
      drain_pct = DRAIN_PCT;
      for (int p = 0; p < PHASES; p++) begin
         case (p % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 85; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 85; end
            default: begin gap_pct = 20; stall_pct = 20; end
         endcase
         if (p % 2 == 0)
            write_threshold(THR_W'($urandom));
         else
            write_threshold(pick_threshold());
         for (int i = 0; i < TICKS_PER_PHASE; i++)
            send_tick(pick_power(), pick_power());
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.owed_pulses.size() != 0)
         sb.report($sformatf("%0d results never arrived", sb.owed_pulses.size()));

      $display("Sent %0d power ticks over %0d threshold settings; %0d results compared.",
               sb.ticks, settings, sb.compared);
      if (sb.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
